// ===== hw/rtl/name_token_validator_assert.svh =====
// Assertion macros for the name token validator top level.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef NAME_TOKEN_VALIDATOR_ASSERT_SVH
`define NAME_TOKEN_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define NTV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define NTV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ntv_pkg.sv =====
// Package for the name token validator: verdict codes, per-name state,
// reserved word constants and character class helpers. No dependencies.
`default_nettype none

package ntv_pkg;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_EMPTY     = 3'd1,
        VERDICT_TOO_LONG  = 3'd2,
        VERDICT_BAD_FIRST = 3'd3,
        VERDICT_BAD_LATER = 3'd4,
        VERDICT_RESERVED  = 3'd5
    } verdict_t;

    localparam int WORD_COUNT = 3;

    // Reserved words, byte 0 in the low bits; bit w of the match flags tracks word w.
    localparam logic [7:0][7:0] WORD_NONE    = 64'h00000000_656E6F6E; // none
    localparam logic [7:0][7:0] WORD_DEFAULT = 64'h00746C75_61666564; // default
    localparam logic [7:0][7:0] WORD_DOMAIN0 = 64'h302D6E69_616D6F44; // Domain-0

    localparam logic [WORD_COUNT-1:0][7:0][7:0] RES_WORDS =
        {WORD_DOMAIN0, WORD_DEFAULT, WORD_NONE};
    localparam logic [WORD_COUNT-1:0][3:0] RES_LENGTHS = {4'd8, 4'd7, 4'd4};

    // Suffix that marks a reserved name; oldest byte in the top slot.
    localparam logic [2:0][7:0] SUFFIX_DM = "-dm";

    localparam logic [7:0] MAX_LEN_RESET = 8'd31;

    typedef struct packed {
        logic [7:0]            char_count;  // bytes seen, saturates at 255
        verdict_t              first_error; // VERDICT_OK means none yet
        logic [2:0][7:0]       recent;      // [0] newest
        logic [WORD_COUNT-1:0] match;       // set while word still matches
    } name_state_t;

    localparam name_state_t NAME_STATE_RESET = '{
        char_count:  8'd0,
        first_error: VERDICT_OK,
        recent:      24'd0,
        match:       {WORD_COUNT{1'b1}}
    };

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_later_ok(input logic [7:0] c);
        return is_letter(c) || (c inside {[8'h30:8'h39], 8'h5F, 8'h2E, 8'h2D});
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ntv_scan.sv =====
// Per-byte name check: next name state and the verdict for one item.
// Purely combinational; uses ntv_pkg.
`default_nettype none

module ntv_scan
    import ntv_pkg::*;
(
    input  name_state_t state,
    input  logic [7:0]  name_char,
    input  logic        char_absent,
    input  logic        last_char,
    input  logic [7:0]  max_len,
    output name_state_t state_next,
    output verdict_t    verdict
);

    name_state_t upd;
    logic [8:0]  len9;
    logic        word_hit;

    // Fold the byte into the running state.
    always_comb
    begin
        upd = state;
        if (!char_absent)
        begin
            if (state.first_error == VERDICT_OK)
            begin
                if (state.char_count == 8'd0)
                begin
                    if (!is_letter(name_char))
                        upd.first_error = VERDICT_BAD_FIRST;
                end
                else if (!is_later_ok(name_char))
                begin
                    upd.first_error = VERDICT_BAD_LATER;
                end
            end
            for (int w = 0; w < WORD_COUNT; w++)
            begin
                if ((state.char_count >= {4'd0, RES_LENGTHS[w]}) ||
                    (RES_WORDS[w][state.char_count[2:0]] != name_char))
                    upd.match[w] = 1'b0;
            end
            upd.recent = {state.recent[1], state.recent[0], name_char};
            if (state.char_count != 8'hFF)
                upd.char_count = state.char_count + 8'd1;
        end
    end

    // Length with this byte, 9 bits so a full count still reads as too long.
    assign len9 = char_absent ? {1'b0, state.char_count}
                              : {1'b0, state.char_count} + 9'd1;

    always_comb
    begin
        word_hit = 1'b0;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            if (upd.match[w] && (len9 == {5'd0, RES_LENGTHS[w]}))
                word_hit = 1'b1;
        end
    end

    always_comb
    begin
        if (len9 == 9'd0)
            verdict = VERDICT_EMPTY;
        else if (len9 > {1'b0, max_len})
            verdict = VERDICT_TOO_LONG;
        else if (upd.first_error != VERDICT_OK)
            verdict = upd.first_error;
        else if ((len9 >= 9'd4) && (upd.recent == SUFFIX_DM))
            verdict = VERDICT_RESERVED;
        else if (word_hit)
            verdict = VERDICT_RESERVED;
        else
            verdict = VERDICT_OK;
    end

    assign state_next = last_char ? NAME_STATE_RESET : upd;

endmodule

`default_nettype wire

// ===== hw/rtl/name_token_validator.sv =====
// Top level of the name token validator: input register, name state,
// verdict register, limit register. Uses ntv_pkg, ntv_scan and the assert macros.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  input    | in        | in_valid / in_stall  | name_char, char_absent, last_char
//  result   | out       | out_valid / out_stall| verdict
//  config   | in        | cfg_valid / cfg_ready| max_name_length
//
// One item per cycle sustained while no last item waits on a stalled result. An
// item is held in the input register, then the scan logic updates the name state;
// a last item loads the verdict register and sets out_valid.
// Reset clears the name state, both valid bits and sets the limit to 31.
// Only a last item waits on a full, stalled result register; in_stall follows.
// cfg_ready is high whenever the input register is empty.
`default_nettype none

`include "name_token_validator_assert.svh"

module name_token_validator
    import ntv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] name_char,
    input  logic       char_absent,
    input  logic       last_char,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] verdict,
    // limit register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] max_name_length
);

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_char_reg;
    logic        s1_absent_reg;
    logic        s1_last_reg;

    // per-name state and limit
    name_state_t state_reg;
    name_state_t state_next;
    logic [7:0]  max_len_reg;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    verdict_t    verdict_reg;
    verdict_t    verdict_calc;

    logic        in_xfer;
    logic        out_free;
    logic        s1_go;
    logic        s1_done;

    // Result slot is free if empty or being drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    // Non-last items never need the result slot.
    assign s1_go    = s1_valid_reg && (!s1_last_reg || out_free);
    assign s1_done  = s1_go && s1_last_reg;
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_xfer  = in_valid && !in_stall;

    ntv_scan u_scan (
        .state       (state_reg),
        .name_char   (s1_char_reg),
        .char_absent (s1_absent_reg),
        .last_char   (s1_last_reg),
        .max_len     (max_len_reg),
        .state_next  (state_next),
        .verdict     (verdict_calc)
    );

    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (s1_done)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= NAME_STATE_RESET;
            max_len_reg   <= MAX_LEN_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_go)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                max_len_reg <= max_name_length;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_char_reg   <= name_char;
            s1_absent_reg <= char_absent;
            s1_last_reg   <= last_char;
        end
        if (s1_done)
            verdict_reg <= verdict_calc;
    end

    assign cfg_ready = !s1_valid_reg;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // A finished name always produces a result in the next cycle.
    `NTV_ASSERT_NEXT(a_done_gives_result, s1_done, out_valid_reg, "verdict lost")
    // No result without a finished name.
    `NTV_ASSERT_NEXT(a_no_spurious_result, !out_valid_reg && !s1_done, !out_valid_reg,
        "result with no name end")
    // The name state is back at reset after each verdict.
    `NTV_ASSERT_NEXT(a_state_cleared, s1_done, state_reg == NAME_STATE_RESET,
        "name state not cleared")
    // Input stalls only behind a last item waiting on a blocked result.
    `NTV_ASSERT_NOW(a_stall_cause, in_stall,
        s1_valid_reg && s1_last_reg && out_valid_reg && out_stall, "stall without cause")

endmodule

`default_nettype wire

// ===== dv/name_token_validator_checker.sv =====
`timescale 1ns / 1ps
// Verdict checker for name_token_validator: watches the input, result and limit channels,
// predicts each verdict and compares it with the one the block returns. Uses ntv_pkg.
module name_token_validator_checker
    import ntv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] name_char,
    input  logic       char_absent,
    input  logic       last_char,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] verdict,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] max_name_length,
    output int         mismatch_count,
    output int         verdicts_pending
);

    localparam logic [7:0] LIMIT_AT_RESET = 8'd31;

    // Reserved words, first byte at index 0.
    localparam logic [0:7][7:0] KW_NONE    = {"none", 32'h0};
    localparam logic [0:7][7:0] KW_DEFAULT = {"default", 8'h0};
    localparam logic [0:7][7:0] KW_DOMAIN0 = "Domain-0";
    localparam logic [0:2][0:7][7:0] KW_TEXT = {KW_NONE, KW_DEFAULT, KW_DOMAIN0};
    localparam logic [0:2][3:0] KW_LEN = {4'd4, 4'd7, 4'd8};

    logic [7:0]      limit;
    logic [7:0]      seen;       // bytes so far, saturating
    verdict_t        first_err;
    logic [2:0][7:0] tail;       // [0] newest
    logic [2:0]      kw_live;    // bit w: still matching word w
    verdict_t        expected_verdicts[$];

    function automatic logic alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic body_char_ok(input logic [7:0] c);
        return alpha(c) || (c >= "0" && c <= "9") || c == "_" || c == "." || c == "-";
    endfunction

    // len is the full name length in 9 bits; state already holds every byte
    function automatic verdict_t grade_name(input logic [8:0] len);
        int w;
        if (len == 9'd0)
            return VERDICT_EMPTY;
        if (len > {1'b0, limit})
            return VERDICT_TOO_LONG;
        if (first_err != VERDICT_OK)
            return first_err;
        if (len >= 9'd4 && tail == "-dm")
            return VERDICT_RESERVED;
        for (w = 0; w < 3; w++)
            if (kw_live[w] && len == {5'd0, KW_LEN[w]})
                return VERDICT_RESERVED;
        return VERDICT_OK;
    endfunction

    task automatic clear_name();
        seen      = 8'd0;
        first_err = VERDICT_OK;
        tail      = '0;
        kw_live   = 3'b111;
    endtask

    task automatic take_byte(input logic [7:0] c);
        int w;
        if (first_err == VERDICT_OK) begin
            if (seen == 8'd0) begin
                if (!alpha(c))
                    first_err = VERDICT_BAD_FIRST;
            end
            else if (!body_char_ok(c)) begin
                first_err = VERDICT_BAD_LATER;
            end
        end
        for (w = 0; w < 3; w++)
            if (seen >= {4'd0, KW_LEN[w]} || KW_TEXT[w][seen[2:0]] != c)
                kw_live[w] = 1'b0;
        tail = {tail[1:0], c};
        if (seen != 8'hFF)
            seen = seen + 8'd1;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: MISMATCH %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic take_input_transfer();
        logic [8:0] len;
        if (char_absent) begin
            if (last_char) begin
                expected_verdicts.push_back(grade_name({1'b0, seen}));
                clear_name();
            end
        end
        else begin
            len = {1'b0, seen} + 9'd1;
            take_byte(name_char);
            if (last_char) begin
                expected_verdicts.push_back(grade_name(len));
                clear_name();
            end
        end
    endtask

    task automatic check_verdict();
        verdict_t want;
        if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0d with no name pending", verdict));
        end
        else begin
            want = expected_verdicts.pop_front();
            if (verdict !== want)
                report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit = LIMIT_AT_RESET;
            clear_name();
            expected_verdicts.delete();
            verdicts_pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                limit = max_name_length;
            if (out_valid && !out_stall)
                check_verdict();
            if (in_valid && !in_stall)
                take_input_transfer();
            verdicts_pending = expected_verdicts.size();
        end
    end

endmodule

// ===== dv/name_token_validator_tb.sv =====
`timescale 1ns / 1ps
// Top of the name_token_validator testbench: clock, reset, stimulus and the final verdict.
// Depends on the block itself and name_token_validator_checker.
module name_token_validator_tb;

    // Cycles with no transfer on any channel before the run is declared hung.
    // The slowest legal stretch is a run of sender gap or receiver stall,
    // plus the settle before a limit write.
    localparam int WATCHDOG_LIMIT = 1000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] name_char = 8'd0;
    logic       char_absent = 1'b0;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] verdict;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] max_name_length = 8'd31;

    int         mismatch_count;
    int         verdicts_pending;

    int         idle_pct = 13;     // sender idle chance per cycle, percent
    int         stall_pct = 13;    // receiver stall chance per cycle, percent
    int         items_sent = 0;    // transfers that carry a byte or end a name
    logic [7:0] cur_limit = 8'd31; // limit the block currently holds
    int         quiet_cycles = 0;
    logic [7:0] name_buf[$];       // bytes of the next name to send

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    name_token_validator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .name_char       (name_char),
        .char_absent     (char_absent),
        .last_char       (last_char),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .verdict         (verdict),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .max_name_length (max_name_length)
    );

    name_token_validator_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .name_char        (name_char),
        .char_absent      (char_absent),
        .last_char        (last_char),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .verdict          (verdict),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .max_name_length  (max_name_length),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending)
    );

    // Receiver side: random stall, changed only on the falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Hang detector: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Entered and left at a falling edge. Valid stays high on exit, so back-to-back
    // transfers never lower and raise it in one step; a gap lowers it first.
    task automatic push_item(input logic [7:0] c, input logic absent, input logic last);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid    <= 1'b1;
        name_char   <= c;
        char_absent <= absent;
        last_char   <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (!(absent && !last))
            items_sent++;
        @(negedge clk);
    endtask

    // Sends name_buf; an empty buffer becomes an empty name. A few byte-less
    // transfers that the block must skip are slipped in at random.
    task automatic send_name(input bit end_absent);
        int i;
        for (i = 0; i < name_buf.size(); i++) begin
            if ($urandom_range(99) < 3)
                push_item(8'($urandom), 1'b1, 1'b0);
            push_item(name_buf[i], 1'b0, !end_absent && (i == name_buf.size() - 1));
        end
        if (end_absent || name_buf.size() == 0)
            push_item(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
    endtask

    task automatic add_repeated(input logic [7:0] c, input int n);
        repeat (n) name_buf.push_back(c);
    endtask

    task automatic send_text(input string s);
        name_buf.delete();
        add_text(s);
        send_name(1'b0);
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'($urandom_range(25));
        return ($urandom_range(1) != 0) ? 8'("a" + c) : 8'("A" + c);
    endfunction

    // Any byte legal after the first one
    function automatic logic [7:0] pick_body_char();
        int r;
        r = $urandom_range(65);
        if (r < 52)
            return pick_letter();
        else if (r < 62)
            return 8'("0" + r - 52);
        else if (r == 62)
            return "_";
        else if (r == 63)
            return ".";
        else
            return "-";
    endfunction

    // Mostly short names, now and then one straddling the current limit.
    function automatic int pick_len();
        int n;
        if ($urandom_range(9) == 0)
            n = int'(cur_limit) + int'($urandom_range(2)) - 1;
        else
            n = $urandom_range(1, 12);
        return (n < 1) ? 1 : n;
    endfunction

    task automatic add_clean(input int n);
        if (n > 0) begin
            name_buf.push_back(pick_letter());
            repeat (n - 1) name_buf.push_back(pick_body_char());
        end
    endtask

    // One random name. Well-formed and near-reserved names dominate so the
    // later checks in the precedence chain get exercised, with noise mixed in.
    task automatic send_random_name();
        int kind;
        int n;
        name_buf.delete();
        kind = $urandom_range(99);
        n = pick_len();
        if (kind < 40) begin
            add_clean(n);
        end
        else if (kind < 52) begin
            case ($urandom_range(2))
                0:       add_text("none");
                1:       add_text("default");
                default: add_text("Domain-0");
            endcase
            case ($urandom_range(3))
                1:       void'(name_buf.pop_back());
                2:       name_buf.push_back(pick_body_char());
                3:       name_buf[$urandom_range(name_buf.size() - 1)] = pick_body_char();
                default: ;
            endcase
        end
        else if (kind < 64) begin
            // "-dm" suffix, sometimes too short to count
            add_clean($urandom_range(3) == 0 ? $urandom_range(1) : ((n > 3) ? n - 3 : 1));
            add_text("-dm");
        end
        else if (kind < 76) begin
            add_clean(n);
            name_buf[$urandom_range(n - 1)] = 8'($urandom_range(255));
        end
        else if (kind < 86) begin
            repeat (n) name_buf.push_back(8'($urandom_range(255)));
        end
        else if (kind < 91) begin
            // empty name
        end
        else begin
            name_buf.push_back(pick_body_char());
            repeat (n - 1) name_buf.push_back(pick_body_char());
        end
        send_name($urandom_range(9) == 0);
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
            send_random_name();
    endtask

    // Limit writes go in only once the block has drained; the settle covers
    // a transfer that is still in flight but produces no verdict.
    task automatic set_limit(input logic [7:0] v);
        in_valid <= 1'b0;
        while (verdicts_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid       <= 1'b1;
        max_name_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed cases at the reset limit of 31
        send_text("");
        send_text("a");
        send_text("Z");
        send_text("none");
        send_text("default");
        send_text("Domain-0");
        send_text("nonex");
        send_text("defaul");
        send_text("Domain-00");
        send_text("DOMAIN-0");
        send_text("x-dm");
        send_text("-dm");
        send_text("1abc");
        send_text("a b");
        send_text("a$b#");        // first error must stick
        send_text("9$");
        send_text("a.b_c-D9");
        name_buf.delete();
        name_buf.push_back(8'h00);
        add_text("a");
        send_name(1'b0);
        name_buf.delete();
        add_text("q");
        name_buf.push_back(8'hFF);
        send_name(1'b0);
        // skipped transfer in mid-name, then a name closed by a byte-less transfer
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item("b", 1'b0, 1'b1);
        send_text("ab");
        send_name(1'b1);
        name_buf.delete();
        add_repeated("x", 31);
        send_name(1'b0);           // exactly at the limit
        name_buf.delete();
        add_text("1");
        add_repeated("x", 31);
        send_name(1'b0);           // too long wins over a bad first byte
        run_random(300);

        // Widest limit, including names past the 8-bit count
        set_limit(8'd255);
        name_buf.delete();
        add_repeated("k", 255);
        send_name(1'b0);
        name_buf.delete();
        add_repeated("k", 258);
        send_name(1'b0);
        run_random(1050);

        // Narrowest limits
        set_limit(8'd1);
        send_text("a");
        send_text("ab");
        run_random(1150);
        set_limit(8'd0);
        send_text("");
        send_text("a");
        run_random(1230);

        // No idling on either side for this stretch
        idle_pct = 0;
        stall_pct = 0;
        set_limit(8'd8);
        send_text("Domain-0");
        send_text("Domain-0x");
        run_random(1450);
        idle_pct = 13;
        stall_pct = 13;

        set_limit(8'($urandom_range(2, 254)));
        run_random(1500);
        set_limit(8'd31);
        run_random(1550);

        in_valid <= 1'b0;
        while (verdicts_pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && verdicts_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
